// File: rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the rgb/hsl color converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam logic [12:0] HUE_FULL  = 13'd5760;
  localparam logic [12:0] HUE_SIXTH = 13'd960;
  localparam logic [12:0] UNIT      = 13'd4096;

  // pipelined restoring divider geometry
  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 9;
  localparam int DIV_QUO_W = 13;

  // total latency of both conversion paths, input edge to result strobe, and the stage count of the hsl to rgb pipeline
  localparam int PIPE_LAT = 16;
  localparam int HSL_LAT  = 5;

  // fixed-point channel datapath width for hsl to rgb
  localparam int V_W = 36;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } rhc_max_t;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } rhc_sector_t;

  typedef enum logic {
    KIND_RGB2HSL = 1'b0,
    KIND_HSL2RGB = 1'b1
  } rhc_kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] hue_in;
    logic [12:0] sat_in;
    logic [12:0] light_in;
  } rhc_in_t;

  typedef struct packed {
    logic [12:0] hue_out;
    logic [12:0] sat_out;
    logic [12:0] light_out;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
  } rhc_out_t;

  typedef struct packed {
    logic        vld;
    logic [12:0] hue;
    logic [12:0] sat;
    logic [12:0] light;
  } rhc_hsl_res_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rhc_rgb_res_t;

endpackage

// File: rtl/core/rgb_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_hsl_converter
// Pixel color converter, rgb to hsl or hsl to rgb per transfer.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  input     start, busy, in_data     transfer when start and not busy
//  result    out_valid, out_data      one-cycle strobe, no backpressure
//
//  a new pixel is taken every clock; busy stays low.
//  each result follows its input transfer through the thirteen stages of the
//  bit-per-stage dividers of the rgb to hsl path plus setup and fixup; the
//  hsl to rgb path is delayed to the same depth.
//  synchronous active-low reset clears all valid bits.
// ----------------------------------------------------------------------------
module rgb_hsl_converter
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rhc_in_t  in_data,
  output logic     out_valid,
  output rhc_out_t out_data
);

  logic         acc_rgb;
  logic         acc_hsl;
  rhc_hsl_res_t hsl_res;
  rhc_rgb_res_t rgb_res;

  assign busy    = 1'b0;
  assign acc_rgb = start && !busy && (in_data.kind == KIND_RGB2HSL);
  assign acc_hsl = start && !busy && (in_data.kind == KIND_HSL2RGB);

  rhc_rgb2hsl u_rgb2hsl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (acc_rgb),
    .red    (in_data.red),
    .green  (in_data.green),
    .blue   (in_data.blue),
    .res    (hsl_res)
  );

  rhc_hsl2rgb u_hsl2rgb (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc_hsl),
    .hue_in   (in_data.hue_in),
    .sat_in   (in_data.sat_in),
    .light_in (in_data.light_in),
    .res      (rgb_res)
  );

  assign out_valid = hsl_res.vld || rgb_res.vld;

  always_comb begin
    out_data = '0;
    if (hsl_res.vld) begin
      out_data.hue_out   = hsl_res.hue;
      out_data.sat_out   = hsl_res.sat;
      out_data.light_out = hsl_res.light;
    end else begin
      out_data.red_out   = rgb_res.red;
      out_data.green_out = rgb_res.green;
      out_data.blue_out  = rgb_res.blue;
    end
  end

`ifndef SYNTHESIS
  a_one_path: assert property (@(posedge clk) disable iff (!rst_n)
    !(hsl_res.vld && rgb_res.vld))
    else $error("both conversion paths strobe in the same cycle");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##16 out_valid)
    else $error("result missing after pipeline latency");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    hsl_res.vld |-> (hsl_res.hue < HUE_FULL))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    hsl_res.vld |-> (hsl_res.sat <= UNIT && hsl_res.light <= UNIT))
    else $error("saturation or lightness above unit");
`endif

endmodule

// File: rtl/core/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rhc_div
  import rhc_pkg::*;
(
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_QUO_W-1:0] quo
);

  logic [DIV_DEN_W-1:0] rem_r [DIV_QUO_W];
  logic [DIV_NUM_W-1:0] num_r [DIV_QUO_W];
  logic [DIV_DEN_W-1:0] den_r [DIV_QUO_W];
  logic [DIV_QUO_W-1:0] quo_r [DIV_QUO_W];

  for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_NUM_W-1:0] num_in;
    logic [DIV_QUO_W-1:0] quo_in;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic [DIV_DEN_W-1:0] rem_nxt;
    logic [DIV_QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      // upper numerator bits are known to stay below the divisor
      assign rem_in = num[DIV_NUM_W-1:DIV_QUO_W];
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      trial = {rem_in, num_in[DIV_QUO_W-1-k]};
      diff  = trial - {1'b0, den_in};
      if (trial >= {1'b0, den_in}) begin
        rem_nxt = diff[DIV_DEN_W-1:0];
        quo_nxt = {quo_in[DIV_QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DEN_W-1:0];
        quo_nxt = {quo_in[DIV_QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      num_r[k] <= num_in;
      den_r[k] <= den_in;
      quo_r[k] <= quo_nxt;
    end
  end

  assign quo = quo_r[DIV_QUO_W-1];

endmodule

// File: rtl/core/rhc_rgb2hsl.sv
// ----------------------------------------------------------------------------
// rhc_rgb2hsl
// RGB to HSL pipeline: min/max, numerators, two dividers, final fixup.
// ----------------------------------------------------------------------------
module rhc_rgb2hsl
  import rhc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [7:0]   red,
  input  logic [7:0]   green,
  input  logic [7:0]   blue,
  output rhc_hsl_res_t res
);

  // stage 1
  logic        s1_vld_r;
  logic        s1_gray_r;
  logic [10:0] s1_t_r;
  logic [7:0]  s1_c_r;
  logic [8:0]  s1_sum_r;

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  c;
  logic [10:0] c6;
  rhc_max_t    msel;
  logic [10:0] t_nxt;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    c  = mx - mn;
    c6 = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
    priority if (mx == red)   msel = MAX_RED;
    else if (mx == green)     msel = MAX_GREEN;
    else                      msel = MAX_BLUE;
    // offset keeps the hue numerator non-negative
    unique case (msel)
      MAX_RED:   t_nxt = {3'b0, green} + c6 - {3'b0, blue};
      MAX_GREEN: t_nxt = {3'b0, blue} + {2'b0, c, 1'b0} - {3'b0, red};
      MAX_BLUE:  t_nxt = {3'b0, red} + {1'b0, c, 2'b00} - {3'b0, green};
      default:   t_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_gray_r <= (c == 8'd0);
    s1_t_r    <= t_nxt;
    s1_c_r    <= c;
    s1_sum_r  <= {1'b0, mx} + {1'b0, mn};
  end

  // stage 2: numerators and divisors
  logic                 s2_vld_r;
  logic                 s2_gray_r;
  logic [DIV_NUM_W-1:0] hue_num_r;
  logic [DIV_DEN_W-1:0] hue_den_r;
  logic [DIV_NUM_W-1:0] sat_num_r;
  logic [DIV_DEN_W-1:0] sat_den_r;
  logic [12:0]          light_quo_r;

  logic [7:0]           den_s;
  logic [19:0]          light_y;
  logic [40:0]          light_prod;

  always_comb begin
    if (s1_sum_r <= 9'd255) begin
      den_s = s1_sum_r[7:0];
    end else begin
      den_s = 8'(9'd510 - s1_sum_r);
    end
    // round(sum * 4096 / 510) = floor((2048 sum + 127) / 255),
    // the divide by 255 is a multiply by (2^28 + 239) / 255 = 2^20 + 2^12 + 2^4 + 1
    light_y    = {s1_sum_r, 11'd127};
    light_prod = {1'b0, light_y, 20'd0} + {9'd0, light_y, 12'd0} +
                 {17'd0, light_y, 4'd0} + {21'd0, light_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_gray_r   <= s1_gray_r;
    // t * 1920 + c
    hue_num_r   <= {s1_t_r, 11'd0} - {4'd0, s1_t_r, 7'd0} + {14'd0, s1_c_r};
    hue_den_r   <= {s1_c_r, 1'b0};
    sat_num_r   <= {1'b0, s1_c_r, 13'd0} + {14'd0, den_s};
    sat_den_r   <= {den_s, 1'b0};
    light_quo_r <= light_prod[40:28];
  end

  logic [DIV_QUO_W-1:0] hue_q;
  logic [DIV_QUO_W-1:0] sat_q;
  logic [12:0]          light_q;

  rhc_div u_div_hue (
    .clk (clk),
    .num (hue_num_r),
    .den (hue_den_r),
    .quo (hue_q)
  );

  rhc_div u_div_sat (
    .clk (clk),
    .num (sat_num_r),
    .den (sat_den_r),
    .quo (sat_q)
  );

  // side bits and lightness ride alongside the divider stages
  logic [DIV_QUO_W-1:0] vld_sh_r;
  logic [DIV_QUO_W-1:0] gray_sh_r;
  logic [12:0]          light_sh_r [DIV_QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sh_r <= '0;
    end else begin
      vld_sh_r <= {vld_sh_r[DIV_QUO_W-2:0], s2_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    gray_sh_r     <= {gray_sh_r[DIV_QUO_W-2:0], s2_gray_r};
    light_sh_r[0] <= light_quo_r;
    for (int i = 1; i < DIV_QUO_W; i++) begin
      light_sh_r[i] <= light_sh_r[i-1];
    end
  end

  assign light_q = light_sh_r[DIV_QUO_W-1];

  // final stage: hue wrap, saturation clamp, gray override
  logic        gray_d;
  logic [12:0] hue_nxt;
  logic [12:0] sat_nxt;
  logic        res_vld_r;
  logic [12:0] res_hue_r;
  logic [12:0] res_sat_r;
  logic [12:0] res_light_r;

  always_comb begin
    gray_d = gray_sh_r[DIV_QUO_W-1];
    if (gray_d) begin
      hue_nxt = '0;
    end else if (hue_q >= HUE_FULL) begin
      hue_nxt = hue_q - HUE_FULL;
    end else begin
      hue_nxt = hue_q;
    end
    if (gray_d) begin
      sat_nxt = '0;
    end else if (sat_q > UNIT) begin
      sat_nxt = UNIT;
    end else begin
      sat_nxt = sat_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= vld_sh_r[DIV_QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    res_hue_r   <= hue_nxt;
    res_sat_r   <= sat_nxt;
    res_light_r <= light_q;
  end

  assign res.vld   = res_vld_r;
  assign res.hue   = res_hue_r;
  assign res.sat   = res_sat_r;
  assign res.light = res_light_r;

endmodule

// File: rtl/core/rhc_hsl2rgb.sv
// ----------------------------------------------------------------------------
// rhc_hsl2rgb
// HSL to RGB pipeline: clamp, chroma product, X and offset, select, round.
// ----------------------------------------------------------------------------
module rhc_hsl2rgb
  import rhc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [12:0]  hue_in,
  input  logic [12:0]  sat_in,
  input  logic [12:0]  light_in,
  output rhc_rgb_res_t res
);

  localparam int PAD = PIPE_LAT - HSL_LAT;

  // stage 1: wrap and clamp, a = 4096 * (1 - |2l - 1|)
  logic        s1_vld_r;
  logic [12:0] s1_h_r;
  logic [12:0] s1_s_r;
  logic [12:0] s1_l_r;
  logic [12:0] s1_a_r;

  logic [12:0] h_w;
  logic [12:0] s_c;
  logic [12:0] l_c;
  logic [13:0] l2;
  logic [13:0] a_w;

  always_comb begin
    h_w = (hue_in >= HUE_FULL) ? hue_in - HUE_FULL : hue_in;
    s_c = (sat_in > UNIT) ? UNIT : sat_in;
    l_c = (light_in > UNIT) ? UNIT : light_in;
    l2  = {l_c, 1'b0};
    a_w = (l2 >= 14'd4096) ? 14'd8192 - l2 : l2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_h_r <= h_w;
    s1_s_r <= s_c;
    s1_l_r <= l_c;
    s1_a_r <= a_w[12:0];
  end

  // stage 2: a * s, sector and triangle weight
  logic        s2_vld_r;
  logic [24:0] s2_as_r;
  rhc_sector_t s2_sec_r;
  logic [9:0]  s2_w_r;
  logic [12:0] s2_l_r;

  rhc_sector_t sec;
  logic [12:0] base;
  logic [10:0] hm;
  logic [10:0] w_full;
  logic [25:0] as_full;

  always_comb begin
    priority if (s1_h_r < 13'd960)  sec = SEC_0;
    else if (s1_h_r < 13'd1920)     sec = SEC_1;
    else if (s1_h_r < 13'd2880)     sec = SEC_2;
    else if (s1_h_r < 13'd3840)     sec = SEC_3;
    else if (s1_h_r < 13'd4800)     sec = SEC_4;
    else                            sec = SEC_5;
    priority if (s1_h_r < 13'd1920) base = 13'd0;
    else if (s1_h_r < 13'd3840)     base = 13'd1920;
    else                            base = 13'd3840;
    hm      = 11'(s1_h_r - base);
    w_full  = (hm >= 11'd960) ? 11'd1920 - hm : hm;
    as_full = s1_a_r * s1_s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_as_r  <= as_full[24:0];
    s2_sec_r <= sec;
    s2_w_r   <= w_full[9:0];
    s2_l_r   <= s1_l_r;
  end

  // stage 3: chroma, X and offset in a common scale
  logic           s3_vld_r;
  rhc_sector_t    s3_sec_r;
  logic [V_W-1:0] s3_cv_r;
  logic [V_W-1:0] s3_xv_r;
  logic [V_W-1:0] s3_mv_r;

  logic [25:0]    mdiff;
  logic [35:0]    xv_full;

  always_comb begin
    mdiff   = {s2_l_r, 13'd0} - {1'b0, s2_as_r};
    xv_full = {s2_as_r, 1'b0} * s2_w_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sec_r <= s2_sec_r;
    s3_xv_r  <= xv_full;
    // as * 1920 and mdiff * 960
    s3_cv_r  <= {s2_as_r, 11'd0} - {4'd0, s2_as_r, 7'd0};
    s3_mv_r  <= {mdiff, 10'd0} - {4'd0, mdiff, 6'd0};
  end

  // stage 4: sector select plus offset
  logic           s4_vld_r;
  logic [V_W-1:0] s4_rv_r;
  logic [V_W-1:0] s4_gv_r;
  logic [V_W-1:0] s4_bv_r;

  logic [V_W-1:0] rc;
  logic [V_W-1:0] gc;
  logic [V_W-1:0] bc;

  always_comb begin
    rc = '0;
    gc = '0;
    bc = '0;
    unique case (s3_sec_r)
      SEC_0: begin
        rc = s3_cv_r;
        gc = s3_xv_r;
      end
      SEC_1: begin
        rc = s3_xv_r;
        gc = s3_cv_r;
      end
      SEC_2: begin
        gc = s3_cv_r;
        bc = s3_xv_r;
      end
      SEC_3: begin
        gc = s3_xv_r;
        bc = s3_cv_r;
      end
      SEC_4: begin
        rc = s3_xv_r;
        bc = s3_cv_r;
      end
      SEC_5: begin
        rc = s3_cv_r;
        bc = s3_xv_r;
      end
      default: begin
        rc = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_rv_r <= rc + s3_mv_r;
    s4_gv_r <= gc + s3_mv_r;
    s4_bv_r <= bc + s3_mv_r;
  end

  // stage 5: round(255 v / scale) reduces to (17 v + 2^30) >> 31
  function automatic logic [7:0] to_chan(input logic [V_W-1:0] v);
    logic [V_W+4:0] acc;
    logic [9:0]     q;
    acc = {1'b0, v, 4'd0} + {5'd0, v} + {11'd1, 30'd0};
    q   = acc[V_W+4:31];
    to_chan = (q > 10'd255) ? 8'd255 : q[7:0];
  endfunction

  logic [PAD:0] vld_sh_r;
  logic [23:0]  rgb_sh_r [PAD+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sh_r <= '0;
    end else begin
      vld_sh_r <= {vld_sh_r[PAD-1:0], s4_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    rgb_sh_r[0] <= {to_chan(s4_rv_r), to_chan(s4_gv_r), to_chan(s4_bv_r)};
    for (int i = 1; i <= PAD; i++) begin
      rgb_sh_r[i] <= rgb_sh_r[i-1];
    end
  end

  // delay line matches the rgb to hsl latency
  assign res.vld   = vld_sh_r[PAD];
  assign res.red   = rgb_sh_r[PAD][23:16];
  assign res.green = rgb_sh_r[PAD][15:8];
  assign res.blue  = rgb_sh_r[PAD][7:0];

endmodule

// File: verif/tb_rgb_hsl_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_hsl_converter
// Drives directed and random pixels of both conversion kinds into the
// converter with random start gaps and checks each result strobe, field by
// field, against a fixed-point predictor kept in order in a queue.
// ----------------------------------------------------------------------------
module tb_rgb_hsl_converter
  import rhc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rhc_in_t  in_data;
  logic     out_valid;
  rhc_out_t out_data;

  rhc_in_t  pixel_q[$];
  rhc_out_t color_q[$];
  int       gap_q[$];
  int       errors;
  int       cycles;
  bit       feeding_done;

  rgb_hsl_converter DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic longint unsigned rnd_div(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [7:0] channel_of(longint unsigned v, longint unsigned dscale);
    longint unsigned q;
    q = rnd_div(255 * v, dscale);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rhc_out_t convert_pixel(rhc_in_t p);
    rhc_out_t        res;
    longint unsigned r, g, b, mx, mn, c, sum, t, hue, den, sat;
    longint unsigned h, s, l, a, as_, hm, w, ds, cv, xv, mv, rc, gc, bc;
    res = '0;
    if (p.kind == KIND_RGB2HSL) begin
      r = p.red; g = p.green; b = p.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      sum = mx + mn;
      res.light_out = 13'(rnd_div(sum * 4096, 510));
      if (c != 0) begin
        if (mx == r) t = g + 6 * c - b;
        else if (mx == g) t = b + 2 * c - r;
        else t = r + 4 * c - g;
        hue = rnd_div(t * 960, c);
        if (hue >= 5760) hue -= 5760;
        res.hue_out = 13'(hue);
        den = (sum <= 255) ? sum : 510 - sum;
        if (den != 0) begin
          sat = rnd_div(c * 4096, den);
          if (sat > 4096) sat = 4096;
          res.sat_out = 13'(sat);
        end
      end
    end else begin
      h = p.hue_in; s = p.sat_in; l = p.light_in;
      if (h >= 5760) h -= 5760;
      if (s > 4096) s = 4096;
      if (l > 4096) l = 4096;
      a = (2 * l >= 4096) ? 4096 - (2 * l - 4096) : 2 * l;
      as_ = a * s;
      hm = h % 1920;
      w = (hm >= 960) ? 1920 - hm : hm;
      ds = 2 * 4096 * 4096 * 960;
      cv = 2 * as_ * 960;
      xv = 2 * as_ * w;
      mv = 960 * (2 * 4096 * l - as_);
      rc = 0; gc = 0; bc = 0;
      if (h < 960) begin rc = cv; gc = xv; end
      else if (h < 1920) begin rc = xv; gc = cv; end
      else if (h < 2880) begin gc = cv; bc = xv; end
      else if (h < 3840) begin gc = xv; bc = cv; end
      else if (h < 4800) begin rc = xv; bc = cv; end
      else begin rc = cv; bc = xv; end
      res.red_out = channel_of(rc + mv, ds);
      res.green_out = channel_of(gc + mv, ds);
      res.blue_out = channel_of(bc + mv, ds);
    end
    return res;
  endfunction

  task automatic add_rgb(int r, int g, int b);
    rhc_in_t p;
    p = '0;
    p.kind = KIND_RGB2HSL;
    p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
    // unused fields carry noise
    p.hue_in = 13'($urandom); p.sat_in = 13'($urandom); p.light_in = 13'($urandom);
    pixel_q.push_back(p);
    gap_q.push_back($urandom_range(0, 10));
  endtask

  task automatic add_hsl(int h, int s, int l);
    rhc_in_t p;
    p = '0;
    p.kind = KIND_HSL2RGB;
    p.hue_in = 13'(h); p.sat_in = 13'(s); p.light_in = 13'(l);
    p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
    pixel_q.push_back(p);
    gap_q.push_back($urandom_range(0, 10));
  endtask

  // low for one cycle after each transfer
  bit busy_seen;

  // driver: gap, then hold start until the transfer
  int  gap_left;
  bit  holding;
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      start <= 1'b0;
    end else begin
      if (holding && !busy_seen) holding = 1'b0;
      if (!holding) begin
        if (pixel_q.size() > 0 && gap_left == 0) begin
          in_data <= pixel_q.pop_front();
          gap_left = gap_q.pop_front();
          start <= 1'b1;
          holding = 1'b1;
        end else begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end
      end
    end
  end

  // capture acceptance and results at the rising edge
  always @(posedge clk) begin
    rhc_out_t want;
    busy_seen <= !(rst_n && start && !busy);
    if (rst_n) begin
      cycles++;
      if (start && !busy) begin
        color_q.push_back(convert_pixel(in_data));
      end
      if (out_valid) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          want = color_q.pop_front();
          if (out_data.hue_out !== want.hue_out)
            $display("%0t: hue_out exp %0d got %0d", $time, want.hue_out, out_data.hue_out);
          if (out_data.sat_out !== want.sat_out)
            $display("%0t: sat_out exp %0d got %0d", $time, want.sat_out, out_data.sat_out);
          if (out_data.light_out !== want.light_out)
            $display("%0t: light_out exp %0d got %0d", $time, want.light_out,
                     out_data.light_out);
          if (out_data.red_out !== want.red_out)
            $display("%0t: red_out exp %0d got %0d", $time, want.red_out, out_data.red_out);
          if (out_data.green_out !== want.green_out)
            $display("%0t: green_out exp %0d got %0d", $time, want.green_out,
                     out_data.green_out);
          if (out_data.blue_out !== want.blue_out)
            $display("%0t: blue_out exp %0d got %0d", $time, want.blue_out, out_data.blue_out);
          if (out_data !== want) errors++;
        end
      end
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n, pick;
    errors = 0;
    cycles = 0;
    gap_left = 0;
    holding = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    // extremes, each max channel, ties and gray
    add_rgb(0, 0, 0);
    add_rgb(255, 255, 255);
    add_rgb(128, 128, 128);
    add_rgb(255, 0, 0);
    add_rgb(0, 255, 0);
    add_rgb(0, 0, 255);
    add_rgb(255, 0, 1);
    add_rgb(255, 255, 0);
    add_rgb(0, 255, 255);
    add_rgb(255, 1, 254);
    add_rgb(1, 0, 0);
    add_rgb(254, 255, 255);
    add_hsl(0, 0, 0);
    add_hsl(0, 4096, 4096);
    add_hsl(0, 4096, 2048);
    add_hsl(5759, 4096, 2048);
    add_hsl(5760, 4096, 2048);
    add_hsl(8191, 8191, 8191);
    add_hsl(960, 4096, 2048);
    add_hsl(1920, 4096, 2048);
    add_hsl(2880, 4096, 2048);
    add_hsl(3840, 4096, 2048);
    add_hsl(4800, 4096, 2048);
    add_hsl(4000, 4097, 2047);
    for (n = 0; n < 850; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) add_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
      else if (pick == 4) add_rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                                  $urandom_range(250, 255));
      else if (pick < 8) add_hsl($urandom_range(0, 5759), $urandom_range(0, 4096),
                                 $urandom_range(0, 4096));
      else add_hsl($urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 8191));
      // stretches without gaps
      if ((n / 100) % 3 == 1) gap_q[gap_q.size() - 1] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pixel_q.size() == 0 && !holding);
    wait (color_q.size() == 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
